[sv/circular_double_ended_queue_assert.svh]
// Assertion helpers used by the deque pointer logic (cdeq_ptr).
// Every check is clocked on clk and held off while arst_n is low.
`ifndef CIRCULAR_DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define CIRCULAR_DOUBLE_ENDED_QUEUE_ASSERT_SVH

// Check a condition at every clock edge.
`define CDEQ_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Check a consequence in the same cycle as its cause.
`define CDEQ_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequence in the cycle after its cause.
`define CDEQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/cdeq_pkg.sv]
package cdeq_pkg;

	// Ring geometry
	localparam int DEPTH  = 8;
	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;

	typedef enum logic [1:0] {
		MODE_PUSH_FRONT = 2'd0,
		MODE_PUSH_REAR  = 2'd1,
		MODE_POP_FRONT  = 2'd2,
		MODE_POP_REAR   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		STAT_DONE       = 2'd0,
		STAT_FULL_REJ   = 2'd1,
		STAT_EMPTY_REJ  = 2'd2,
		STAT_UNUSED     = 2'd3
	} status_t;

	typedef struct packed {
		mode_t                     mode;
		logic signed [DATA_W-1:0]  value;
	} in_item_t;

	typedef struct packed {
		status_t                   status;
		logic [3:0]                occupancy;
		logic                      is_empty;
		logic                      is_full;
		logic signed [DATA_W-1:0]  front_value;
		logic signed [DATA_W-1:0]  rear_value;
	} out_item_t;

	// Write request from the index logic to the ring memories
	typedef struct packed {
		logic               en;
		logic [IDX_W-1:0]   addr;
		logic [DATA_W-1:0]  data;
	} ring_wr_t;

	// Queue bookkeeping as it stands after the last transaction
	typedef struct packed {
		logic [IDX_W-1:0]  head;
		logic [IDX_W-1:0]  tail;
		logic [CNT_W-1:0]  count;
		logic              empty;
		logic              full;
	} ring_info_t;

endpackage

[sv/cdeq_ram.sv]
module cdeq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [ADDR_W-1:0]        waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [ADDR_W-1:0]        raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port, holds its data between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[sv/cdeq_ptr.sv]
`include "circular_double_ended_queue_assert.svh"

module cdeq_ptr import cdeq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  in_item_t    item,
	output status_t     status,
	output ring_wr_t    wr,
	output ring_info_t  info
);

	logic [IDX_W-1:0]  head_q, tail_q, head_n, tail_n;
	logic [CNT_W-1:0]  count_q, count_n;
	logic              empty_q, empty_n;
	logic              full;

	assign full = (count_q == CNT_W'(DEPTH));

	function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
		return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + IDX_W'(1);
	endfunction

	function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] idx);
		return (idx == '0) ? IDX_W'(DEPTH - 1) : idx - IDX_W'(1);
	endfunction

	// Decide the next indices, the count and the entry to write
	always_comb begin
		head_n  = head_q;
		tail_n  = tail_q;
		count_n = count_q;
		empty_n = empty_q;
		status  = STAT_DONE;
		wr.en   = 1'b0;
		wr.addr = '0;
		wr.data = item.value;
		unique case (item.mode) inside
			MODE_PUSH_FRONT, MODE_PUSH_REAR: begin
				if (full) begin
					status = STAT_FULL_REJ;
				end else if (empty_q) begin
					head_n  = '0;
					tail_n  = '0;
					empty_n = 1'b0;
					count_n = CNT_W'(1);
					wr.en   = 1'b1;
					wr.addr = '0;
				end else if (item.mode == MODE_PUSH_FRONT) begin
					head_n  = idx_dec(head_q);
					count_n = count_q + CNT_W'(1);
					wr.en   = 1'b1;
					wr.addr = idx_dec(head_q);
				end else begin
					tail_n  = idx_inc(tail_q);
					count_n = count_q + CNT_W'(1);
					wr.en   = 1'b1;
					wr.addr = idx_inc(tail_q);
				end
			end
			MODE_POP_FRONT, MODE_POP_REAR: begin
				if (empty_q) begin
					status = STAT_EMPTY_REJ;
				end else if (head_q == tail_q) begin
					head_n  = '0;
					tail_n  = '0;
					empty_n = 1'b1;
					count_n = '0;
				end else if (item.mode == MODE_POP_FRONT) begin
					head_n  = idx_inc(head_q);
					count_n = count_q - CNT_W'(1);
				end else begin
					tail_n  = idx_dec(tail_q);
					count_n = count_q - CNT_W'(1);
				end
			end
			default: begin
				status = STAT_DONE;
			end
		endcase
	end

	// Commit the bookkeeping on an accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			empty_q <= 1'b1;
		end else if (fire) begin
			head_q  <= head_n;
			tail_q  <= tail_n;
			count_q <= count_n;
			empty_q <= empty_n;
		end
	end

	assign info.head  = head_q;
	assign info.tail  = tail_q;
	assign info.count = count_q;
	assign info.empty = empty_q;
	assign info.full  = full;

	`CDEQ_ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(DEPTH), "count above depth")
	`CDEQ_ASSERT_ALWAYS(a_empty_count, empty_q == (count_q == '0), "empty flag and count disagree")
	`CDEQ_ASSERT_SAME(a_empty_idx, empty_q, (head_q == '0) && (tail_q == '0), "empty ring with nonzero index")
	`CDEQ_ASSERT_NEXT(a_reject_hold, fire && (status != STAT_DONE), $stable(count_q) && $stable(head_q) && $stable(tail_q), "rejected transaction changed state")

endmodule

[sv/circular_double_ended_queue.sv]
// Double-ended queue over a ring of DEPTH 32-bit words (DEPTH from cdeq_pkg). Each input
// transaction pushes or pops at either end and returns exactly one result with the status,
// occupancy, empty and full flags, and the front and rear words (zero when empty). A push
// into a full ring or a pop from an empty one is rejected and changes nothing. One
// transaction is in flight at a time. The update and memory write happen at acceptance;
// head and tail are then read in the S_READ state, and the read data is captured into the
// output register in S_CAPT, once that register is free. The input is ready again in the
// cycle after the capture, so a new transaction is not taken before the last one has been
// captured. The two ring memories are mirrored copies written together, so front and rear
// are read in the same cycle. The next transaction is accepted while a finished result
// still waits in the output register; a result that cannot be loaded because the previous
// one is still waiting holds the sequencer until it drains.
module circular_double_ended_queue import cdeq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_item_t   in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output out_item_t  out_data
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_READ = 3'b010,
		S_CAPT = 3'b100
	} state_t;

	state_t      state_q;
	status_t     status, status_q;
	ring_wr_t    wr;
	ring_info_t  info;
	logic        fire;
	logic        rd_en;
	logic        load;
	logic        out_valid_q;
	out_item_t   out_data_q;
	logic [DATA_W-1:0] front_rd, rear_rd;

	assign in_ready = (state_q == S_IDLE);
	assign fire     = in_valid && in_ready;
	assign rd_en    = (state_q == S_READ);
	assign load     = (state_q == S_CAPT) && (!out_valid_q || out_ready);

	cdeq_ptr u_ptr (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (in_data),
		.status (status),
		.wr     (wr),
		.info   (info)
	);

	// Front copy of the ring
	cdeq_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram_front (
		.clk   (clk),
		.we    (fire && wr.en),
		.waddr (wr.addr),
		.wdata (wr.data),
		.re    (rd_en),
		.raddr (info.head),
		.rdata (front_rd)
	);

	// Rear copy of the ring
	cdeq_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram_rear (
		.clk   (clk),
		.we    (fire && wr.en),
		.waddr (wr.addr),
		.wdata (wr.data),
		.re    (rd_en),
		.raddr (info.tail),
		.rdata (rear_rd)
	);

	// Sequence one transaction: update, read, capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (fire) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_CAPT;
				end
				S_CAPT: begin
					if (load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Hold the status of the transaction in flight
	always_ff @(posedge clk) begin
		if (fire) begin
			status_q <= status;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload, words forced to zero on an empty ring
	always_ff @(posedge clk) begin
		if (load) begin
			out_data_q.status      <= status_q;
			out_data_q.occupancy   <= 4'(info.count);
			out_data_q.is_empty    <= info.empty;
			out_data_q.is_full     <= info.full;
			out_data_q.front_value <= info.empty ? '0 : front_rd;
			out_data_q.rear_value  <= info.empty ? '0 : rear_rd;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
